// File: sv/rise_time_measurement_unit_defines.svh
// ----------------------------------------------------------------------------
// Rise time measurement unit: assertion macros
// Shared concurrent assertion forms, clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef RISE_TIME_MEASUREMENT_UNIT_DEFINES_SVH
`define RISE_TIME_MEASUREMENT_UNIT_DEFINES_SVH

// same-cycle implication
`define RTMU_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RTMU_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/rtmu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rise time measurement unit package
// Widths, register codes, control/status structs and saturation helper.
// ----------------------------------------------------------------------------
package rtmu_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int TIME_W     = 48;
	localparam int FRAC_W     = 16;
	localparam int PERIOD_W   = 32;
	localparam int COUNT_W    = 32;
	localparam int ACC_W      = 64;
	localparam int RES_W      = 48;
	localparam int IN_DATA_W  = SAMPLE_W + TIME_W;
	localparam int OUT_DATA_W = 4 * RES_W + COUNT_W;
	localparam int OUT_USER_W = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int STEP_W     = 7;

	localparam logic [STEP_W-1:0] DIV_SHORT_STEPS = STEP_W'(32);
	localparam logic [STEP_W-1:0] DIV_LONG_STEPS  = STEP_W'(64);

	localparam logic signed [SAMPLE_W-1:0] START_LEVEL_RST = -16'sd19661;
	localparam logic signed [SAMPLE_W-1:0] END_LEVEL_RST   = 16'sd19661;
	localparam logic [PERIOD_W-1:0]        PERIOD_RST      = 32'd1000000;

	localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
	localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_LEVEL   = 2'd0,
		REG_END_LEVEL     = 2'd1,
		REG_SAMPLE_PERIOD = 2'd2
	} cfg_reg_t;

	localparam logic KIND_MEAS    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic latch_in;
		logic div_start;
		logic div_long;
		logic mul_load;
		logic xt_load;
		logic set_start;
		logic rise_load;
		logic emit_meas;
		logic post;
		logic avg_load;
		logic emit_sum;
	} rtmu_cmd_t;

	typedef struct packed {
		logic crossing;
		logic phase;
		logic eor;
		logic count_zero;
		logic div_busy;
		logic out_free;
	} rtmu_stat_t;

	// signed 64 -> signed 48 with clamping
	function automatic logic [RES_W-1:0] sat_res(input logic [ACC_W-1:0] v);
		logic fits;
		fits = (v[ACC_W-1:RES_W-1] == {(ACC_W-RES_W+1){1'b0}})
			|| (v[ACC_W-1:RES_W-1] == {(ACC_W-RES_W+1){1'b1}});
		if (fits)
			return v[RES_W-1:0];
		else if (v[ACC_W-1])
			return RES_MIN;
		else
			return RES_MAX;
	endfunction

endpackage

// File: sv/rtmu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rise time measurement unit controller
// Sequences one request through detect, divide, scale, emit and summary.
// ----------------------------------------------------------------------------
module rtmu_ctrl import rtmu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  rtmu_stat_t stat,
	output rtmu_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV_WAIT,
		ST_MUL,
		ST_XT,
		ST_RISE,
		ST_EMIT,
		ST_POST,
		ST_AVG_WAIT,
		ST_AVG,
		ST_SUM
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.crossing) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV_WAIT;
				end else begin
					state_d = ST_POST;
				end
			end
			ST_DIV_WAIT: begin
				if (!stat.div_busy) state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_load = 1'b1;
				state_d      = ST_XT;
			end
			ST_XT: begin
				cmd.xt_load = 1'b1;
				state_d     = ST_RISE;
			end
			ST_RISE: begin
				if (stat.phase) begin
					cmd.rise_load = 1'b1;
					state_d       = ST_EMIT;
				end else begin
					cmd.set_start = 1'b1;
					state_d       = ST_POST;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit_meas = 1'b1;
					state_d       = ST_POST;
				end
			end
			ST_POST: begin
				cmd.post = 1'b1;
				if (!stat.eor) begin
					state_d = ST_IDLE;
				end else if (stat.count_zero) begin
					state_d = ST_SUM;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_long  = 1'b1;
					state_d       = ST_AVG_WAIT;
				end
			end
			ST_AVG_WAIT: begin
				if (!stat.div_busy) state_d = ST_AVG;
			end
			ST_AVG: begin
				cmd.avg_load = 1'b1;
				state_d      = ST_SUM;
			end
			ST_SUM: begin
				if (stat.out_free) begin
					cmd.emit_sum = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

endmodule

// File: sv/rtmu_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rise time measurement unit datapath
// Config, edge state, shared radix-2 divider, scaler, accumulator, output reg.
// ----------------------------------------------------------------------------
module rtmu_dpath import rtmu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [IN_DATA_W-1:0]  in_data,
	input  logic                  in_last,
	input  logic                  out_ready,
	input  rtmu_cmd_t             cmd,
	output rtmu_stat_t            stat,
	output logic                  out_valid,
	output logic [OUT_DATA_W-1:0] out_data,
	output logic [OUT_USER_W-1:0] out_user,
	output logic                  out_last
);

	// config
	logic signed [SAMPLE_W-1:0] start_level_q, end_level_q;
	logic [PERIOD_W-1:0]        period_q;

	// latched request
	logic signed [SAMPLE_W-1:0] cur_q;
	logic [TIME_W-1:0]          tnow_q;
	logic                       eor_q;

	// measurement state
	logic                       phase_q;
	logic signed [SAMPLE_W-1:0] prev_q;
	logic                       prev_valid_q;
	logic [ACC_W-1:0]           edge_start_q;
	logic [TIME_W-1:0]          prev_end_q;
	logic [ACC_W-1:0]           sum_q;
	logic [COUNT_W-1:0]         count_q;

	// divider
	logic [ACC_W-1:0]    dvd_q;
	logic [COUNT_W-1:0]  rem_q, dsr_q;
	logic [STEP_W-1:0]   steps_q;
	logic                div_busy_q;

	logic [FRAC_W+PERIOD_W-1:0] prod_q;
	logic [ACC_W-1:0]           xt_q;
	logic [RES_W-1:0]           rise_q, avg_q;

	logic signed [SAMPLE_W-1:0] level;
	logic signed [SAMPLE_W:0]   num_w, den_w;
	logic [COUNT_W:0]           rem_sh;
	logic                       ge;
	logic [ACC_W-1:0]           sum_abs, avg_s, rise_ext, sum_add;
	logic                       sum_ovf;

	assign level = phase_q ? end_level_q : start_level_q;
	assign num_w = {level[SAMPLE_W-1], level} - {prev_q[SAMPLE_W-1], prev_q};
	assign den_w = {cur_q[SAMPLE_W-1], cur_q} - {prev_q[SAMPLE_W-1], prev_q};

	assign stat.crossing   = prev_valid_q && (cur_q > level) && (prev_q <= level);
	assign stat.phase      = phase_q;
	assign stat.eor        = eor_q;
	assign stat.count_zero = (count_q == '0);
	assign stat.div_busy   = div_busy_q;
	assign stat.out_free   = !out_valid || out_ready;

	// restoring division step
	assign rem_sh = {rem_q, dvd_q[ACC_W-1]};
	assign ge     = rem_sh >= {1'b0, dsr_q};

	assign sum_abs  = sum_q[ACC_W-1] ? (~sum_q + ACC_W'(1)) : sum_q;
	assign avg_s    = sum_q[ACC_W-1] ? (~dvd_q + ACC_W'(1)) : dvd_q;
	assign rise_ext = {{(ACC_W-RES_W){rise_q[RES_W-1]}}, rise_q};
	assign sum_add  = sum_q + rise_ext;
	assign sum_ovf  = (sum_q[ACC_W-1] == rise_ext[ACC_W-1])
		&& (sum_add[ACC_W-1] != sum_q[ACC_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_level_q <= START_LEVEL_RST;
			end_level_q   <= END_LEVEL_RST;
			period_q      <= PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_LEVEL:   start_level_q <= cfg_data[SAMPLE_W-1:0];
				REG_END_LEVEL:     end_level_q   <= cfg_data[SAMPLE_W-1:0];
				REG_SAMPLE_PERIOD: period_q      <= cfg_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			cur_q  <= in_data[SAMPLE_W-1:0];
			tnow_q <= in_data[IN_DATA_W-1:SAMPLE_W];
			eor_q  <= in_last;
		end
		if (cmd.mul_load)
			prod_q <= dvd_q[FRAC_W-1:0] * period_q;
		if (cmd.xt_load)
			xt_q <= {{(ACC_W-TIME_W){1'b0}}, tnow_q} - {{(ACC_W-PERIOD_W){1'b0}}, period_q}
				+ {{(ACC_W-PERIOD_W){1'b0}}, prod_q[FRAC_W+PERIOD_W-1:FRAC_W]};
		if (cmd.rise_load)
			rise_q <= sat_res(xt_q - edge_start_q);
		if (cmd.avg_load)
			avg_q <= sat_res(avg_s);
		if (cmd.div_start) begin
			rem_q <= '0;
			if (cmd.div_long) begin
				dvd_q <= sum_abs;
				dsr_q <= count_q;
			end else begin
				dvd_q <= {num_w[SAMPLE_W-1:0], {(ACC_W-SAMPLE_W){1'b0}}};
				dsr_q <= {{(COUNT_W-SAMPLE_W){1'b0}}, den_w[SAMPLE_W-1:0]};
			end
		end else if (div_busy_q) begin
			rem_q <= ge ? COUNT_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[COUNT_W-1:0];
			dvd_q <= {dvd_q[ACC_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			steps_q    <= '0;
		end else if (cmd.div_start) begin
			div_busy_q <= 1'b1;
			steps_q    <= cmd.div_long ? DIV_LONG_STEPS : DIV_SHORT_STEPS;
		end else if (div_busy_q) begin
			div_busy_q <= (steps_q != STEP_W'(1));
			steps_q    <= steps_q - STEP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= 1'b0;
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
			edge_start_q <= '0;
			prev_end_q   <= '0;
			sum_q        <= '0;
			count_q      <= '0;
		end else begin
			if (cmd.set_start) begin
				edge_start_q <= xt_q;
				phase_q      <= 1'b1;
			end
			if (cmd.emit_meas) begin
				prev_end_q <= tnow_q;
				phase_q    <= 1'b0;
				sum_q      <= sum_ovf ? (sum_q[ACC_W-1] ? ACC_MIN : ACC_MAX) : sum_add;
				if (count_q != '1) count_q <= count_q + COUNT_W'(1);
			end
			if (cmd.post) begin
				prev_q       <= cur_q;
				prev_valid_q <= 1'b1;
			end
			if (cmd.emit_sum) begin
				phase_q      <= 1'b0;
				prev_q       <= '0;
				prev_valid_q <= 1'b0;
				edge_start_q <= '0;
				prev_end_q   <= '0;
				sum_q        <= '0;
				count_q      <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.emit_meas || cmd.emit_sum) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_meas) begin
			out_data <= {{COUNT_W{1'b0}}, {RES_W{1'b0}}, TIME_W'(tnow_q - prev_end_q),
				prev_end_q, rise_q};
			out_user <= {1'b0, KIND_MEAS};
			out_last <= !eor_q;
		end else if (cmd.emit_sum) begin
			out_data <= {stat.count_zero ? {COUNT_W{1'b0}} : count_q,
				stat.count_zero ? {RES_W{1'b0}} : avg_q,
				{TIME_W{1'b0}}, {TIME_W{1'b0}}, {RES_W{1'b0}}};
			out_user <= {stat.count_zero, KIND_SUMMARY};
			out_last <= 1'b1;
		end
	end

endmodule

// File: sv/rise_time_measurement_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rise time measurement unit
// Measures start-to-end level crossing times on a timestamped sample stream.
// ----------------------------------------------------------------------------
// Usage:
//  - s_* carries one sample request: s_tdata = {sample_time, sample_value},
//    s_tlast marks the last sample of a record.
//  - m_* carries results: a rise measurement (m_tuser[0] = 0) when the end
//    level is crossed, and a record summary (m_tuser[0] = 1) after s_tlast.
//    m_tlast is set on the last result caused by one request.
//  - cfg_we/cfg_index/cfg_data write start level, end level, sample period;
//    write only while the unit is idle.
// Sequencing: one request at a time. A start crossing runs a 32-step fraction
//  division, a multiply and two adds; an end crossing runs the same and then
//  waits until the output is free. A record end with edges adds a 64-step
//  average division, done by the same bit-serial divider.
// Reset: config returns to its defaults, all edge and record state clears.
// Stall: a result waits in the output register; the next request is still
//  taken, and the unit holds only when it must load a new result.
// ----------------------------------------------------------------------------
`include "rise_time_measurement_unit_defines.svh"

module rise_time_measurement_unit import rtmu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// config write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// sample stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // sample_value, sample_time
	input  logic                  s_tlast,  // end_of_record
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// rise_time, interval_start, interval_length, average_rise, edge_count
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [OUT_USER_W-1:0] m_tuser,  // result_kind, no_edges
	output logic                  m_tlast   // last_of_run
);

	rtmu_cmd_t  cmd;
	rtmu_stat_t stat;

	// sequencer
	rtmu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// arithmetic and state
	rtmu_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.in_last   (s_tlast),
		.out_ready (m_tready),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.out_user  (m_tuser),
		.out_last  (m_tlast)
	);

	`RTMU_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "request overlap")
	`RTMU_ASSERT_NOW(a_no_overwrite, cmd.emit_meas || cmd.emit_sum, !m_tvalid || m_tready, "result overwritten")
	`RTMU_ASSERT_NOW(a_summary_last, m_tvalid && m_tuser[0], m_tlast, "summary without last")
	`RTMU_ASSERT_NOW(a_empty_count, m_tvalid && m_tuser[1], m_tdata[OUT_DATA_W-1:4*RES_W] == '0, "empty record count")

endmodule

// File: test/tb_rise_time_measurement_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rise time measurement unit testbench
// Drives sample records through the stream port, predicts each rise
// measurement and record summary in a local model, checks every result.
// ----------------------------------------------------------------------------
module tb_rise_time_measurement_unit;
	import rtmu_pkg::*;

	typedef struct packed {
		logic            kind;
		logic [RES_W-1:0] rise;
		logic [RES_W-1:0] ivl_start;
		logic [RES_W-1:0] ivl_len;
		logic [RES_W-1:0] avg;
		logic [COUNT_W-1:0] count;
		logic            no_edges;
		logic            last;
	} rise_result_t;

	localparam int LIMIT = 2000000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	logic                  m_tlast;

	rise_time_measurement_unit uut (.*);

	// model copy of registers and state
	logic signed [63:0] lvl_start, lvl_end;
	logic [63:0]        period;
	logic               ph;
	logic signed [63:0] prev_s;
	logic               prev_ok;
	logic [63:0]        t_edge, t_prev_end;
	logic signed [63:0] sum;
	logic [63:0]        cnt;

	rise_result_t expected_results[$];
	int errors;
	int cycles;
	int send_idle_pct, recv_stall_pct;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	function automatic logic [63:0] cross_time(input logic [63:0] tnow,
			input logic signed [63:0] p, input logic signed [63:0] c,
			input logic signed [63:0] lvl);
		logic [63:0] num, den, frac, off;
		logic [127:0] prod;
		num  = lvl - p;
		den  = c - p;
		frac = (num << FRAC_W) / den;
		prod = frac * period;
		off  = prod[63+FRAC_W:FRAC_W];
		return tnow - period + off;
	endfunction

	function automatic logic [RES_W-1:0] clamp48(input logic signed [63:0] v);
		if (v > 64'sd140737488355327) return RES_MAX;
		if (v < -64'sd140737488355328) return RES_MIN;
		return v[RES_W-1:0];
	endfunction

	task automatic clear_record();
		ph = 0; prev_s = 0; prev_ok = 0; t_edge = 0; t_prev_end = 0; sum = 0; cnt = 0;
	endtask

	// expected results of one sample
	task automatic predict_sample(input logic [15:0] v, input logic [47:0] t, input logic eor);
		logic signed [63:0] cur, rise, avg;
		logic [63:0] tend, tn;
		rise_result_t r;
		cur = $signed(v);
		tn = {16'd0, t};
		if (!ph) begin
			if (prev_ok && cur > lvl_start && prev_s <= lvl_start) begin
				t_edge = cross_time(tn, prev_s, cur, lvl_start);
				ph = 1;
			end
		end else if (prev_ok && cur > lvl_end && prev_s <= lvl_end) begin
			tend = cross_time(tn, prev_s, cur, lvl_end);
			rise = $signed(clamp48($signed(tend - t_edge)));
			r = '0;
			r.rise = rise[47:0];
			r.ivl_start = t_prev_end[47:0];
			r.ivl_len = tn[47:0] - t_prev_end[47:0];
			r.last = !eor;
			expected_results = {expected_results, r};
			t_prev_end = tn;
			if (rise > 0 && sum > 64'sh7FFFFFFFFFFFFFFF - rise) sum = 64'sh7FFFFFFFFFFFFFFF;
			else if (rise < 0 && sum < $signed(64'h8000000000000000) - rise)
				sum = $signed(64'h8000000000000000);
			else sum = sum + rise;
			if (cnt < 64'hFFFFFFFF) cnt++;
			ph = 0;
		end
		prev_s = cur;
		prev_ok = 1;
		if (eor) begin
			r = '0;
			r.kind = KIND_SUMMARY;
			r.last = 1;
			if (cnt == 0) r.no_edges = 1;
			else begin
				avg = sum / $signed(cnt);
				r.avg = clamp48(avg);
				r.count = cnt[31:0];
			end
			expected_results = {expected_results, r};
			clear_record();
		end
	endtask

	task automatic send_sample(input logic [15:0] v, input logic [47:0] t, input logic eor);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {t, v};
		s_tlast  <= eor;
		predict_sample(v, t, eor);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// receiver stall pattern
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// result checker
	always @(posedge clk) begin
		rise_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report("unexpected result", m_tdata[63:0], 64'd0);
			end else begin
				want = expected_results.pop_front();
				if (m_tuser[0] !== want.kind) report("kind", m_tuser[0], want.kind);
				if (m_tuser[1] !== want.no_edges) report("no_edges", m_tuser[1], want.no_edges);
				if (m_tlast !== want.last) report("last", m_tlast, want.last);
				if (m_tdata[47:0] !== want.rise) report("rise", m_tdata[47:0], want.rise);
				if (m_tdata[95:48] !== want.ivl_start)
					report("interval_start", m_tdata[95:48], want.ivl_start);
				if (m_tdata[143:96] !== want.ivl_len)
					report("interval_length", m_tdata[143:96], want.ivl_len);
				if (m_tdata[191:144] !== want.avg) report("average", m_tdata[191:144], want.avg);
				if (m_tdata[223:192] !== want.count) report("count", m_tdata[223:192], want.count);
			end
		end
	end

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_START_LEVEL: lvl_start = $signed(val[15:0]);
			REG_END_LEVEL:   lvl_end = $signed(val[15:0]);
			REG_SAMPLE_PERIOD: period = {32'd0, val};
			default: ;
		endcase
		@(negedge clk);
	endtask

	// running timestamp for well-formed records
	logic [47:0] now_fs;

	// one record: random samples below the start level, above the end level, near the start level, or anywhere
	task automatic send_record(input int len);
		int i;
		logic [15:0] v;
		for (i = 0; i < len; i++) begin
			now_fs = 48'(now_fs + period[47:0] + $urandom_range(3) - 1);
			case ($urandom_range(3))
				0: v = 16'(lvl_start[15:0] - $urandom_range(2000));
				1: v = 16'(lvl_end[15:0] + $urandom_range(2000));
				2: v = 16'(lvl_start[15:0] + $urandom_range(20));
				default: v = 16'($urandom);
			endcase
			send_sample(v, now_fs, i == len - 1);
		end
	endtask

	task automatic test_directed();
		send_sample(16'h8000, 48'd0, 1'b0);            // first sample, no crossing
		send_sample(16'h7FFF, 48'd1000000, 1'b0);      // start crossing only
		send_sample(16'h8000, 48'd2000000, 1'b0);
		send_sample(16'h7FFF, 48'd3000000, 1'b0);      // end crossing
		send_sample(16'd0, 48'hFFFF_FFFF_FFFF, 1'b1);  // record end, summary
		send_sample(16'd0, 48'd5, 1'b1);               // empty record
		send_sample(16'h8000, 48'd10, 1'b0);
		send_sample(16'h7FFF, 48'd20, 1'b0);
		send_sample(16'h8000, 48'd30, 1'b0);
		send_sample(16'h7FFF, 48'd40, 1'b1);           // measurement then summary
		send_sample(16'hB333, 48'hFFFF_FFFF_FF00, 1'b0);
		send_sample(16'hB334, 48'hFFFF_FFFF_FFF0, 1'b0);
		send_sample(16'h4CCD, 48'h0000_0000_0010, 1'b0); // time wrap
		send_sample(16'h4CCE, 48'h0000_0000_0020, 1'b1);
		drain();
	endtask

	task automatic test_config_extremes();
		write_reg(REG_SAMPLE_PERIOD, 32'd0);           // all offsets zero
		write_reg(REG_START_LEVEL, 32'h8000);
		write_reg(REG_END_LEVEL, 32'h7FFE);
		now_fs = 48'd100;
		send_record(12);
		drain();
		write_reg(REG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
		write_reg(REG_END_LEVEL, 32'h8001);
		send_record(12);
		drain();
		write_reg(REG_START_LEVEL, 32'hFFFF_0000);
		write_reg(REG_END_LEVEL, 32'd500);
		write_reg(REG_SAMPLE_PERIOD, 32'd1);
		send_record(10);
		drain();
	endtask

	task automatic test_random(input int idle, input int stall, input int n);
		int sent;
		int len;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		write_reg(REG_START_LEVEL, $urandom_range(16'hFFFF));
		write_reg(REG_END_LEVEL, $urandom_range(3000));
		write_reg(REG_SAMPLE_PERIOD, $urandom_range(1, 2000000));
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(9) == 0) begin
				send_sample(16'($urandom), 48'({$urandom, $urandom}), 1'($urandom_range(1)));
				sent += 1;
			end else begin
				len = $urandom_range(4, 30);
				send_record(len);
				sent += len;
			end
		end
		drain();
	endtask

	initial begin
		errors = 0; cycles = 0;
		send_idle_pct = 0; recv_stall_pct = 0;
		arst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0; m_tready = 1'b1;
		lvl_start = -64'sd19661; lvl_end = 64'sd19661; period = 64'd1000000;
		clear_record();
		now_fs = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_config_extremes();
		test_random(0, 0, 95);
		test_random(74, 0, 95);
		test_random(0, 74, 95);
		test_random(20, 20, 95);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
